// ===== sv/amx_pkg.sv =====
// shared types, codes and defaults for the adjacency matrix graph store
package amx_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int LABEL_BITS_DEF   = 8;

  localparam int MODE_BITS   = 2;
  localparam int VERTEX_BITS = 8;
  localparam int STATUS_BITS = 3;
  localparam int VCOUNT_BITS = 5;
  localparam int ECOUNT_BITS = 8;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_INS_V = 2'd0,
    MODE_INS_E = 2'd1,
    MODE_DEL_E = 2'd2,
    MODE_DEL_V = 2'd3
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE        = 3'd0,
    ST_FULL        = 3'd1,
    ST_EXISTS      = 3'd2,
    ST_MISSING     = 3'd3,
    ST_EDGE_EXISTS = 3'd4,
    ST_NO_EDGE     = 3'd5
  } status_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]   mode;
    logic [VERTEX_BITS-1:0] vertex_a;
    logic [VERTEX_BITS-1:0] vertex_b;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [VCOUNT_BITS-1:0] vertex_count;
    logic [ECOUNT_BITS-1:0] edge_count;
  } rsp_t;

  // committed operation, broadcast to every cell
  typedef struct packed {
    logic ins_v;
    logic ins_e;
    logic del_e;
    logic del_v;
  } op_t;

endpackage

// ===== sv/adjacency_matrix_graph_store.sv =====
// top level of the undirected graph store: request control, counts and the row of cells
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  amx_pkg::req_t  mode, vertex_a, vertex_b
//  rsp      out  rsp_valid/rsp_ready  amx_pkg::rsp_t  status, vertex_count, edge_count
//
//  the label compare for an item runs in all cells at acceptance, and
//  the update or compaction shift through the cell row runs afterwards in S_EXEC,
//  where the update waits while a previous result still sits in the output register
//  rst is synchronous: counts, adjacency rows and degrees clear, labels are left as is
//  a new item is taken as soon as the update has committed, even with rsp unread
module adjacency_matrix_graph_store #(
  parameter int MAX_VERTICES = amx_pkg::MAX_VERTICES_DEF,
  parameter int LABEL_BITS   = amx_pkg::LABEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  amx_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output amx_pkg::rsp_t rsp
);

  localparam int VW  = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_VERTICES * (MAX_VERTICES + 1) / 2 + 1);
  localparam int LW  = (LABEL_BITS > amx_pkg::VERTEX_BITS) ? LABEL_BITS : amx_pkg::VERTEX_BITS;
  localparam int VOW = (VW > amx_pkg::VCOUNT_BITS) ? VW : amx_pkg::VCOUNT_BITS;
  localparam int EOW = (EW > amx_pkg::ECOUNT_BITS) ? EW : amx_pkg::ECOUNT_BITS;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                  state;
  amx_pkg::mode_t          mode_q;
  logic [LABEL_BITS-1:0]   label_q;
  logic [MAX_VERTICES-1:0] hit_a_q;
  logic [MAX_VERTICES-1:0] hit_b_q;
  logic [VW-1:0]           vcount;
  logic [EW-1:0]           ecount;
  logic [VW-1:0]           vcount_next;
  logic [EW-1:0]           ecount_next;

  // labels in their low LABEL_BITS bits
  logic [LW-1:0]           ext_a;
  logic [LW-1:0]           ext_b;
  logic [LABEL_BITS-1:0]   lab_a;
  logic [LABEL_BITS-1:0]   lab_b;

  // per-cell wiring
  logic [MAX_VERTICES-1:0] live;
  logic [MAX_VERTICES-1:0] tail;
  logic [MAX_VERTICES-1:0] match_a;
  logic [MAX_VERTICES-1:0] match_b;
  logic [MAX_VERTICES-1:0] edge_here;
  logic [MAX_VERTICES-1:0] keep_low;
  logic [LABEL_BITS-1:0]   labels [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rows   [MAX_VERTICES];
  logic [VW-1:0]           degs   [MAX_VERTICES];

  logic                    exec_go;
  logic                    found_a;
  logic                    found_b;
  logic                    edge_found;
  logic [VW-1:0]           deg_sel;
  amx_pkg::status_t        status_c;
  amx_pkg::op_t            op;
  logic [VOW-1:0]          vc_ext;
  logic [EOW-1:0]          ec_ext;
  logic                    dead_rows_clear;

  assign ext_a = LW'(req.vertex_a);
  assign ext_b = LW'(req.vertex_b);
  assign lab_a = ext_a[LABEL_BITS-1:0];
  assign lab_b = ext_b[LABEL_BITS-1:0];

  assign req_ready = (state == S_IDLE);
  // the update commits only once the output register can take its result
  assign exec_go   = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  assign found_a    = |hit_a_q;
  assign found_b    = |hit_b_q;
  assign edge_found = |edge_here;
  // cells at and above the deleted position take their upper neighbor
  assign keep_low   = hit_a_q - MAX_VERTICES'(1);

  always_comb begin
    deg_sel         = '0;
    dead_rows_clear = 1'b1;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live[i] = (VW'(i) < vcount);
      tail[i] = (VW'(i) == vcount);
      deg_sel = deg_sel | (hit_a_q[i] ? degs[i] : '0);
      if (!live[i] && (rows[i] != '0)) begin
        dead_rows_clear = 1'b0;
      end
    end
  end

  // status of the pending item, from the registered compare
  always_comb begin
    case (mode_q)
      amx_pkg::MODE_INS_V: begin
        if (vcount == VW'(MAX_VERTICES)) begin
          status_c = amx_pkg::ST_FULL;
        end else if (found_a) begin
          status_c = amx_pkg::ST_EXISTS;
        end else begin
          status_c = amx_pkg::ST_DONE;
        end
      end
      amx_pkg::MODE_INS_E: begin
        if (!found_a || !found_b) begin
          status_c = amx_pkg::ST_MISSING;
        end else if (edge_found) begin
          status_c = amx_pkg::ST_EDGE_EXISTS;
        end else begin
          status_c = amx_pkg::ST_DONE;
        end
      end
      amx_pkg::MODE_DEL_E: begin
        if (!found_a || !found_b) begin
          status_c = amx_pkg::ST_MISSING;
        end else if (!edge_found) begin
          status_c = amx_pkg::ST_NO_EDGE;
        end else begin
          status_c = amx_pkg::ST_DONE;
        end
      end
      amx_pkg::MODE_DEL_V: begin
        status_c = found_a ? amx_pkg::ST_DONE : amx_pkg::ST_MISSING;
      end
      default: begin
        status_c = amx_pkg::ST_MISSING;
      end
    endcase
  end

  always_comb begin
    op.ins_v = exec_go && (mode_q == amx_pkg::MODE_INS_V) && (status_c == amx_pkg::ST_DONE);
    op.ins_e = exec_go && (mode_q == amx_pkg::MODE_INS_E) && (status_c == amx_pkg::ST_DONE);
    op.del_e = exec_go && (mode_q == amx_pkg::MODE_DEL_E) && (status_c == amx_pkg::ST_DONE);
    op.del_v = exec_go && (mode_q == amx_pkg::MODE_DEL_V) && (status_c == amx_pkg::ST_DONE);

    vcount_next = vcount;
    ecount_next = ecount;
    if (op.ins_v) begin
      vcount_next = vcount + VW'(1);
    end
    if (op.ins_e) begin
      ecount_next = ecount + EW'(1);
    end
    if (op.del_e) begin
      ecount_next = ecount - EW'(1);
    end
    if (op.del_v) begin
      // degree of the removed vertex counts a self-loop once
      vcount_next = vcount - VW'(1);
      ecount_next = ecount - EW'(deg_sel);
    end
    vc_ext = VOW'(vcount_next);
    ec_ext = EOW'(ecount_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rsp       <= '0;
      vcount    <= '0;
      ecount    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state            <= S_IDLE;
            rsp_valid        <= 1'b1;
            rsp.status       <= status_c;
            rsp.vertex_count <= vc_ext[amx_pkg::VCOUNT_BITS-1:0];
            rsp.edge_count   <= ec_ext[amx_pkg::ECOUNT_BITS-1:0];
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      vcount <= vcount_next;
      ecount <= ecount_next;
    end
  end

  // captured item and compare hits
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      mode_q  <= amx_pkg::mode_t'(req.mode);
      label_q <= lab_a;
      hit_a_q <= match_a;
      hit_b_q <= match_b;
    end
  end

  // row of cells, each fed by its upper neighbor; the top cell shifts in an empty vertex
  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    logic [LABEL_BITS-1:0]   nb_label;
    logic [MAX_VERTICES-1:0] nb_row;
    logic [VW-1:0]           nb_deg;

    if (g == MAX_VERTICES - 1) begin : g_top
      assign nb_label = '0;
      assign nb_row   = '0;
      assign nb_deg   = '0;
    end else begin : g_mid
      assign nb_label = labels[g+1];
      assign nb_row   = rows[g+1];
      assign nb_deg   = degs[g+1];
    end

    amx_cell #(
      .MAX_VERTICES (MAX_VERTICES),
      .LABEL_BITS   (LABEL_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .live       (live[g]),
      .tail       (tail[g]),
      .shift      (~keep_low[g]),
      .sel_a      (hit_a_q[g]),
      .sel_b      (hit_b_q[g]),
      .hit_a      (hit_a_q),
      .hit_b      (hit_b_q),
      .keep_low   (keep_low),
      .cmp_a      (lab_a),
      .cmp_b      (lab_b),
      .new_label  (label_q),
      .next_label (nb_label),
      .next_row   (nb_row),
      .next_deg   (nb_deg),
      .match_a    (match_a[g]),
      .match_b    (match_b[g]),
      .edge_here  (edge_here[g]),
      .label      (labels[g]),
      .row        (rows[g]),
      .deg        (degs[g])
    );
  end

  // a label is held in at most one position
  a_unique_label : assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_a))
    else $error("label matched in more than one cell");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    vcount <= VW'(MAX_VERTICES))
    else $error("vertex count above capacity");

  // rows past the held vertices stay empty, so a new vertex starts with no edges
  a_dead_rows : assert property (@(posedge clk) disable iff (rst)
    dead_rows_clear)
    else $error("stale adjacency bits beyond the held vertices");

  a_del_v_count : assert property (@(posedge clk) disable iff (rst)
    op.del_v |=> (vcount == $past(vcount) - VW'(1)))
    else $error("vertex delete did not shrink the list by one");

  a_result_after_exec : assert property (@(posedge clk) disable iff (rst)
    exec_go |=> (rsp_valid && (state == S_IDLE)))
    else $error("committed item produced no result");

endmodule

// ===== sv/amx_cell.sv =====
// one list position: label, adjacency row and degree, shifting down from its neighbor
module amx_cell #(
  parameter int MAX_VERTICES = amx_pkg::MAX_VERTICES_DEF,
  parameter int LABEL_BITS   = amx_pkg::LABEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  amx_pkg::op_t                         op,
  input  logic                                 live,
  input  logic                                 tail,
  input  logic                                 shift,
  input  logic                                 sel_a,
  input  logic                                 sel_b,
  input  logic [MAX_VERTICES-1:0]              hit_a,
  input  logic [MAX_VERTICES-1:0]              hit_b,
  input  logic [MAX_VERTICES-1:0]              keep_low,
  input  logic [LABEL_BITS-1:0]                cmp_a,
  input  logic [LABEL_BITS-1:0]                cmp_b,
  input  logic [LABEL_BITS-1:0]                new_label,
  input  logic [LABEL_BITS-1:0]                next_label,
  input  logic [MAX_VERTICES-1:0]              next_row,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]    next_deg,
  output logic                                 match_a,
  output logic                                 match_b,
  output logic                                 edge_here,
  output logic [LABEL_BITS-1:0]                label,
  output logic [MAX_VERTICES-1:0]              row,
  output logic [$clog2(MAX_VERTICES+1)-1:0]    deg
);

  localparam int DW = $clog2(MAX_VERTICES + 1);

  logic [MAX_VERTICES-1:0] src_row;
  logic [DW-1:0]           src_deg;
  logic [MAX_VERTICES-1:0] row_next;
  logic [DW-1:0]           deg_next;
  logic                    touched;

  assign match_a   = live && (label == cmp_a);
  assign match_b   = live && (label == cmp_b);
  assign edge_here = sel_a && (|(row & hit_b));
  assign touched   = sel_a || sel_b;

  always_comb begin
    src_row  = shift ? next_row : row;
    src_deg  = shift ? next_deg : deg;
    row_next = row;
    deg_next = deg;
    if (op.ins_v && tail) begin
      row_next = '0;
      deg_next = '0;
    end else if (op.ins_e && touched) begin
      // a self-loop sets one bit and counts once
      row_next = row | (sel_a ? hit_b : '0) | (sel_b ? hit_a : '0);
      deg_next = deg + DW'(1);
    end else if (op.del_e && touched) begin
      row_next = row & ~(sel_a ? hit_b : '0) & ~(sel_b ? hit_a : '0);
      deg_next = deg - DW'(1);
    end else if (op.del_v) begin
      // drop the removed column, higher columns move down one
      row_next = (src_row & keep_low) | ((src_row >> 1) & ~keep_low);
      deg_next = src_deg - DW'(|(src_row & hit_a));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      deg <= '0;
    end else begin
      row <= row_next;
      deg <= deg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op.ins_v && tail) begin
      label <= new_label;
    end else if (op.del_v && shift) begin
      label <= next_label;
    end
  end

endmodule
